/* rtl/cfgcrc_pkg.sv */
// Shared types and constants of the configurable MSB-first CRC core.
package cfgcrc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NbitsW   = 4;
  localparam int unsigned BytesW   = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CrcOutW  = 32;

  // Short queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [NbitsW-1:0]   FullByteBits  = 4'd8;
  localparam logic [BytesW-1:0]   ResetCrcBytes = 3'd4;
  localparam logic [CfgDataW-1:0] ResetPoly     = 32'h04C1_1DB7;
  localparam logic [CfgDataW-1:0] ResetInit     = 32'h0000_0000;
  localparam logic [CfgDataW-1:0] ResetXorOut   = 32'h0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCrcBytes   = 2'd0,
    CfgPolynomial = 2'd1,
    CfgInitValue  = 2'd2,
    CfgXorOut     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic [NbitsW-1:0] nbits;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [BytesW-1:0]   crc_bytes;
    logic [CfgDataW-1:0] poly;
    logic [CfgDataW-1:0] init;
    logic [CfgDataW-1:0] xor_out;
  } cfg_t;

endpackage

/* rtl/cfgcrc_if.sv */
// Stream interfaces for message bytes in and CRC results out.
interface cfgcrc_in_if;
  logic                         valid;
  logic                         ready;
  logic [cfgcrc_pkg::ByteW-1:0]  data_byte;
  logic [cfgcrc_pkg::NbitsW-1:0] valid_bits;
  logic                         last;

  modport source (output valid, data_byte, valid_bits, last, input ready);
  modport sink   (input valid, data_byte, valid_bits, last, output ready);
endinterface

interface cfgcrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [cfgcrc_pkg::CrcOutW-1:0] crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

/* rtl/cfgcrc_front.sv */
// Front stage: accepts input transactions, clamps the bit count and registers the item.
module cfgcrc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  cfgcrc_in_if.sink          in_i,
  output logic               item_valid_o,
  output cfgcrc_pkg::item_t  item_o,
  input  logic               item_ready_i
);
  import cfgcrc_pkg::*;

  logic  valid_d, valid_q;
  item_t item_d, item_q;
  logic  accept;

  assign in_i.ready = !valid_q || item_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    item_d      = item_q;
    valid_d     = valid_q;
    if (item_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d    = 1'b1;
      item_d.data = in_i.data_byte;
      item_d.last = in_i.last;
      // counts above a byte saturate
      item_d.nbits = (in_i.valid_bits > FullByteBits) ? FullByteBits : in_i.valid_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/cfgcrc_queue.sv */
// Two-entry queue decoupling the front stage from the CRC engine.
module cfgcrc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  cfgcrc_pkg::item_t  push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output cfgcrc_pkg::item_t  pop_item_o,
  input  logic               pop_ready_i
);
  import cfgcrc_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QueueCntW-1:0] count_d, count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q < QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    logic [QueuePtrW-1:0] r;
    r = (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count missed a pop");

endmodule

/* rtl/cfgcrc_back.sv */
// CRC engine: folds up to eight bits per transaction and registers the final CRC.
module cfgcrc_back #(
  parameter int unsigned CrcMaxBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfgcrc_pkg::cfg_t   cfg_i,
  input  logic               item_valid_i,
  input  cfgcrc_pkg::item_t  item_i,
  output logic               item_ready_o,
  cfgcrc_out_if.source       out_o
);
  import cfgcrc_pkg::*;

  localparam int unsigned MaxBytesRaw = CrcMaxBits / 8;
  localparam int unsigned MaxBytes    = (MaxBytesRaw < 1) ? 1 :
                                        ((MaxBytesRaw > 4) ? 4 : MaxBytesRaw);
  localparam int unsigned IdxW        = $clog2(CrcMaxBits);

  logic [BytesW-1:0]     eff_bytes;
  logic [IdxW-1:0]       top_idx;
  logic [CrcMaxBits-1:0] mask, poly_m, rem_start, rem_new, crc_d, crc_q;
  logic [CrcMaxBits-1:0] rem_d, rem_q;
  logic                  in_msg_d, in_msg_q, out_valid_d, out_valid_q;
  logic                  fb, pop;

  always_comb begin
    if (cfg_i.crc_bytes == '0) begin
      eff_bytes = 3'd1;
    end else if (cfg_i.crc_bytes > BytesW'(MaxBytes)) begin
      eff_bytes = BytesW'(MaxBytes);
    end else begin
      eff_bytes = cfg_i.crc_bytes;
    end
    top_idx = IdxW'({3'(eff_bytes - 3'd1), 3'b111});
    for (int k = 0; k < CrcMaxBits; k++) begin
      mask[k] = (k <= int'(top_idx));
    end
  end

  assign poly_m    = cfg_i.poly[CrcMaxBits-1:0] & mask;
  assign rem_start = in_msg_q ? (rem_q & mask) : (cfg_i.init[CrcMaxBits-1:0] & mask);

  always_comb begin
    rem_new = rem_start;
    fb      = 1'b0;
    for (int i = 0; i < ByteW; i++) begin
      if (i < int'(item_i.nbits)) begin
        fb      = rem_new[top_idx] ^ item_i.data[ByteW-1-i];
        rem_new = (rem_new << 1) & mask;
        if (fb) begin
          rem_new = rem_new ^ poly_m;
        end
      end
    end
  end

  assign item_ready_o = !item_i.last || !out_valid_q || out_o.ready;
  assign pop          = item_valid_i && item_ready_o;
  assign crc_d        = (rem_new ^ cfg_i.xor_out[CrcMaxBits-1:0]) & mask;

  always_comb begin
    rem_d       = rem_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      rem_d    = rem_new;
      in_msg_d = !item_i.last;
      if (item_i.last) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      crc_q <= crc_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = CrcOutW'(crc_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop && item_i.last))
    else $error("result raised without a last transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && item_i.last |=> !in_msg_q && out_valid_q)
    else $error("message not closed after last transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && pop |-> !item_i.last)
    else $error("pending result overwritten");

endmodule

/* rtl/configurable_msb_first_crc_core.sv */
// Top level of the configurable MSB-first CRC core: registers, front, queue and engine.
// The last byte passes the front register and queue before the engine registers the CRC.
// Throughput: one byte per cycle while no result waits on out_o.ready; each byte folds
// combinationally through an eight-step bit-serial XOR chain in the CRC engine.
// Reset: asynchronous active low; clears the queue, the open-message flag and the
// result valid flag, and loads the default width, polynomial, initial value and final XOR.
module configurable_msb_first_crc_core #(
  parameter int unsigned CrcMaxBits = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cfgcrc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [cfgcrc_pkg::CfgDataW-1:0]      cfg_data_i,
  cfgcrc_in_if.sink                            in_i,
  cfgcrc_out_if.source                         out_o
);
  import cfgcrc_pkg::*;

  cfg_t  cfg_d, cfg_q;
  logic  front_valid, front_ready, q_valid, q_ready;
  item_t front_item, q_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgCrcBytes:   cfg_d.crc_bytes = cfg_data_i[BytesW-1:0];
        CfgPolynomial: cfg_d.poly      = cfg_data_i;
        CfgInitValue:  cfg_d.init      = cfg_data_i;
        CfgXorOut:     cfg_d.xor_out   = cfg_data_i;
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_bytes <= ResetCrcBytes;
      cfg_q.poly      <= ResetPoly;
      cfg_q.init      <= ResetInit;
      cfg_q.xor_out   <= ResetXorOut;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfgcrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (front_ready)
  );

  cfgcrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_item_i  (front_item),
    .push_ready_o (front_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready)
  );

  cfgcrc_back #(
    .CrcMaxBits (CrcMaxBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_ready_o (q_ready),
    .out_o        (out_o)
  );

endmodule
